FILE: src/brfifo_pkg.sv
`default_nettype none

package brfifo_pkg;

    // Field widths fixed by the interface
    localparam int CFG_W  = 4;
    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 9;
    localparam int FILL_W = 9;

    // Capacity exponent after reset
    localparam logic [CFG_W-1:0] CAP_LOG2_RESET = 4'd8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_SKIP  = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the incoming word
        logic execute;   // carry out the latched operation
    } cmd_t;

endpackage

`default_nettype wire

FILE: src/brfifo_ctrl.sv
`default_nettype none

module brfifo_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output brfifo_pkg::cmd_t       cmd,
    output logic                   busy,
    output logic                   done
);

    brfifo_pkg::state_t state_reg;
    brfifo_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brfifo_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brfifo_pkg::ST_IDLE,
            brfifo_pkg::ST_DONE:
            begin
                state_next = start ? brfifo_pkg::ST_EXEC : brfifo_pkg::ST_IDLE;
            end
            brfifo_pkg::ST_EXEC:
            begin
                state_next = brfifo_pkg::ST_DONE;
            end
            default:
            begin
                state_next = brfifo_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy        = 1'b0;
        done        = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            brfifo_pkg::ST_IDLE:
            begin
                cmd.capture = start;
            end
            brfifo_pkg::ST_EXEC:
            begin
                busy        = 1'b1;
                cmd.execute = 1'b1;
            end
            brfifo_pkg::ST_DONE:
            begin
                done        = 1'b1;
                cmd.capture = start;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/brfifo_dp.sv
`default_nettype none

module brfifo_dp
#(
    parameter int DEPTH = 256
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire brfifo_pkg::cmd_t                 cmd,
    input  wire logic                             cfg_we,
    input  wire logic [brfifo_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic [brfifo_pkg::OP_W-1:0]      operation,
    input  wire logic [brfifo_pkg::BYTE_W-1:0]    data_in,
    input  wire logic [brfifo_pkg::BYTE_W-1:0]    peek_offset,
    input  wire logic [brfifo_pkg::CNT_W-1:0]     skip_count,
    output logic      [brfifo_pkg::BYTE_W-1:0]    data_out,
    output logic                                  ok,
    output logic      [brfifo_pkg::FILL_W-1:0]    fill_level,
    output logic                                  is_empty,
    output logic                                  is_full
);

    // Largest usable exponent, floor(log2(DEPTH))
    localparam int MAXLOG = $clog2(DEPTH + 1) - 1;
    localparam int AW     = MAXLOG;
    localparam int CW     = MAXLOG + 1;
    localparam int WW     = (CW > brfifo_pkg::FILL_W) ? CW : brfifo_pkg::FILL_W;
    localparam int SLOTS  = 1 << AW;

    localparam logic [brfifo_pkg::CFG_W-1:0] MAXLOG_K = brfifo_pkg::CFG_W'(MAXLOG);

    logic [brfifo_pkg::CFG_W-1:0]  cap_log2_reg;
    logic [CW-1:0]                 wr_reg;
    logic [CW-1:0]                 rd_reg;
    logic [CW-1:0]                 wr_next;
    logic [CW-1:0]                 rd_next;

    logic [brfifo_pkg::OP_W-1:0]   op_reg;
    logic [brfifo_pkg::BYTE_W-1:0] din_reg;
    logic [brfifo_pkg::BYTE_W-1:0] off_reg;
    logic [brfifo_pkg::CNT_W-1:0]  cnt_reg;

    logic [brfifo_pkg::BYTE_W-1:0] mem [SLOTS];
    logic [brfifo_pkg::BYTE_W-1:0] mem_q_reg;
    logic                          hit_reg;
    logic                          ok_reg;
    logic [WW-1:0]                 fill_reg;
    logic                          empty_reg;
    logic                          full_reg;

    logic [brfifo_pkg::CFG_W-1:0]  k_eff;
    logic [WW-1:0]                 cap_w;
    logic [AW-1:0]                 slot_mask;
    logic [CW-1:0]                 fill_c;
    logic [WW-1:0]                 fill_w;
    logic [WW-1:0]                 off_w;
    logic [WW-1:0]                 cnt_w;
    logic [WW-1:0]                 skip_n;
    logic [WW-1:0]                 peek_w;
    logic [CW-1:0]                 fill_n;
    logic [WW-1:0]                 fill_nw;
    logic                          we;
    logic                          re;
    logic [AW-1:0]                 waddr;
    logic [AW-1:0]                 raddr;
    logic                          ok_c;

    // Effective capacity exponent, clamped to [1, MAXLOG]
    always_comb
    begin
        if (cap_log2_reg == '0)
        begin
            k_eff = brfifo_pkg::CFG_W'(1);
        end
        else if (cap_log2_reg > MAXLOG_K)
        begin
            k_eff = MAXLOG_K;
        end
        else
        begin
            k_eff = cap_log2_reg;
        end
    end

    assign cap_w     = WW'(1) << k_eff;
    assign slot_mask = AW'(cap_w - WW'(1));
    assign fill_c    = wr_reg - rd_reg;
    assign fill_w    = WW'(fill_c);
    assign off_w     = WW'(off_reg);
    assign cnt_w     = WW'(cnt_reg);
    assign skip_n    = (cnt_w < fill_w) ? cnt_w : fill_w;
    assign peek_w    = WW'(rd_reg) + off_w;

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        we      = 1'b0;
        re      = 1'b0;
        waddr   = wr_reg[AW-1:0] & slot_mask;
        raddr   = rd_reg[AW-1:0] & slot_mask;
        ok_c    = 1'b0;
        unique case (brfifo_pkg::op_t'(op_reg))
            brfifo_pkg::OP_PUSH:
            begin
                if (fill_w < cap_w)
                begin
                    we      = 1'b1;
                    wr_next = wr_reg + CW'(1);
                    ok_c    = 1'b1;
                end
            end
            brfifo_pkg::OP_POP:
            begin
                if (fill_w != '0)
                begin
                    re      = 1'b1;
                    rd_next = rd_reg + CW'(1);
                    ok_c    = 1'b1;
                end
            end
            brfifo_pkg::OP_PEEK:
            begin
                if (off_w < fill_w)
                begin
                    re    = 1'b1;
                    raddr = peek_w[AW-1:0] & slot_mask;
                    ok_c  = 1'b1;
                end
            end
            brfifo_pkg::OP_SKIP:
            begin
                rd_next = rd_reg + skip_n[CW-1:0];
                ok_c    = (cnt_w <= fill_w);
            end
            brfifo_pkg::OP_CLEAR:
            begin
                wr_next = '0;
                rd_next = '0;
                ok_c    = 1'b1;
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase
    end

    assign fill_n  = wr_next - rd_next;
    assign fill_nw = WW'(fill_n);

    // Config and pointers; a capacity write also empties the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_log2_reg <= brfifo_pkg::CAP_LOG2_RESET;
            wr_reg       <= '0;
            rd_reg       <= '0;
        end
        else if (cfg_we)
        begin
            cap_log2_reg <= cfg_wdata;
            wr_reg       <= '0;
            rd_reg       <= '0;
        end
        else if (cmd.execute)
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            din_reg <= data_in;
            off_reg <= peek_offset;
            cnt_reg <= skip_count;
        end
    end

    // Ring storage
    always_ff @(posedge clk)
    begin
        if (cmd.execute && we)
        begin
            mem[waddr] <= din_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && re)
        begin
            mem_q_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            hit_reg   <= re;
            ok_reg    <= ok_c;
            fill_reg  <= fill_nw;
            empty_reg <= (fill_nw == '0);
            full_reg  <= (fill_nw == cap_w);
        end
    end

    assign data_out   = hit_reg ? mem_q_reg : '0;
    assign ok         = ok_reg;
    assign fill_level = fill_reg[brfifo_pkg::FILL_W-1:0];
    assign is_empty   = empty_reg;
    assign is_full    = full_reg;

endmodule

`default_nettype wire

FILE: src/byte_ring_fifo_with_peek_skip_unit.sv
`default_nettype none

// Byte FIFO over a power-of-two ring with peek and skip.
//
// Command channel: present operation, data_in, peek_offset and skip_count
// with start; the word is taken on a rising edge where start is high and
// busy is low. busy is high for the single execute cycle that follows.
// Result channel: one result word per command, shown for exactly one cycle
// with done high, after the execute cycle has registered it. A new command
// may be taken in the cycle its predecessor's result is shown, but not
// while busy is high.
// Config: cfg_we writes cfg_wdata into the capacity exponent (clamped to
// 1..log2(DEPTH)) and empties the FIFO; write only while no command is
// in flight.
// Reset (rst_n low, asynchronous): pointers cleared, capacity exponent 8,
// no result pending. The ring itself is not cleared; nothing stale is read.
// The receiver cannot stall: each result must be sampled when done is high.
module byte_ring_fifo_with_peek_skip_unit
#(
    parameter int DEPTH = 256
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    output logic                                  done,
    input  wire logic                             cfg_we,
    input  wire logic [brfifo_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic [brfifo_pkg::OP_W-1:0]      operation,
    input  wire logic [brfifo_pkg::BYTE_W-1:0]    data_in,
    input  wire logic [brfifo_pkg::BYTE_W-1:0]    peek_offset,
    input  wire logic [brfifo_pkg::CNT_W-1:0]     skip_count,
    output logic      [brfifo_pkg::BYTE_W-1:0]    data_out,
    output logic                                  ok,
    output logic      [brfifo_pkg::FILL_W-1:0]    fill_level,
    output logic                                  is_empty,
    output logic                                  is_full
);

    brfifo_pkg::cmd_t cmd;

    // Sequencer: idle -> execute -> result
    brfifo_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Pointers, ring memory and result registers
    brfifo_dp
    #(
        .DEPTH (DEPTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .operation   (operation),
        .data_in     (data_in),
        .peek_offset (peek_offset),
        .skip_count  (skip_count),
        .data_out    (data_out),
        .ok          (ok),
        .fill_level  (fill_level),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

endmodule

`default_nettype wire

FILE: src/brfifo_chk.sv
`default_nettype none

module brfifo_chk
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic                             busy,
    input  wire logic                             done,
    input  wire logic [brfifo_pkg::BYTE_W-1:0]    data_out,
    input  wire logic                             ok,
    input  wire logic                             is_empty,
    input  wire logic                             is_full
);

    // A taken command keeps the block busy the next cycle
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but busy not raised");

    // Execute cycle is always followed by exactly one result
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execute cycle not followed by result");

    // Result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Failed operations return a zero byte
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (data_out == '0))
        else $error("non-zero byte on failed operation");

    // Never empty and full at once while a result is shown
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(is_empty && is_full))
        else $error("empty and full both set");

endmodule

bind byte_ring_fifo_with_peek_skip_unit brfifo_chk u_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .data_out (data_out),
    .ok       (ok),
    .is_empty (is_empty),
    .is_full  (is_full)
);

`default_nettype wire

FILE: tb/tb_byte_ring_fifo_with_peek_skip_unit.sv
`default_nettype none

module tb_byte_ring_fifo_with_peek_skip_unit;

    // Field widths and command codes, taken from the package by name.
    localparam int CFG_W  = brfifo_pkg::CFG_W;
    localparam int OP_W   = brfifo_pkg::OP_W;
    localparam int BYTE_W = brfifo_pkg::BYTE_W;
    localparam int CNT_W  = brfifo_pkg::CNT_W;
    localparam int FILL_W = brfifo_pkg::FILL_W;

    localparam brfifo_pkg::op_t OP_PUSH  = brfifo_pkg::OP_PUSH;
    localparam brfifo_pkg::op_t OP_POP   = brfifo_pkg::OP_POP;
    localparam brfifo_pkg::op_t OP_PEEK  = brfifo_pkg::OP_PEEK;
    localparam brfifo_pkg::op_t OP_SKIP  = brfifo_pkg::OP_SKIP;
    localparam brfifo_pkg::op_t OP_CLEAR = brfifo_pkg::OP_CLEAR;

    // Ring geometry as built: 256 slots, so the exponent tops out at 8 and the
    // free-running pointers are one bit wider than a slot index.
    localparam int RING_DEPTH = 256;
    localparam int MAX_LOG2   = 8;

    // Codes the package leaves unnamed; the block must treat them as no-ops.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // Run length guard and the settle time after the last result.
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_REPORTS = 50;

    // One result word as the block presents it.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic              ok;
        logic [FILL_W-1:0] level;
        logic              empty;
        logic              full;
    } fifo_result_t;

    localparam fifo_result_t NO_RESULT = '0;

    typedef enum logic { ROW_WORD, ROW_CAPACITY } row_kind_t;

    // Traffic shapes for the random part: filling, draining, or a blend.
    typedef enum int { MODE_FILL = 0, MODE_DRAIN = 1, MODE_BLEND = 2 } traffic_mode_t;

    // A directed row: either a command word or a capacity write. Where
    // typed is set, the expected word is given here rather than predicted.
    typedef struct packed {
        row_kind_t         kind;
        logic [OP_W-1:0]   code;
        logic [BYTE_W-1:0] din;
        logic [BYTE_W-1:0] off;
        logic [CNT_W-1:0]  cnt;
        logic [CFG_W-1:0]  cap_setting;
        logic              typed;
        fifo_result_t      want;
    } script_row_t;

    localparam int SCRIPT_ROWS = 26;

    // Starts from reset (256 slots, empty), walks the refusals, then shrinks
    // the ring to its smallest and probes the clamps at both ends of the
    // exponent register.
    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        // empty ring: pop, peek and oversize skip refuse, zero skip succeeds
        '{ROW_WORD, OP_POP,   8'hFF, 8'hFF, 9'h1FF, 4'd0, 1'b1, '{8'h00, 1'b0, 9'd0, 1'b1, 1'b0}},
        '{ROW_WORD, OP_PEEK,  8'h00, 8'h00, 9'h000, 4'd0, 1'b1, '{8'h00, 1'b0, 9'd0, 1'b1, 1'b0}},
        '{ROW_WORD, OP_SKIP,  8'hFF, 8'hFF, 9'h000, 4'd0, 1'b1, '{8'h00, 1'b1, 9'd0, 1'b1, 1'b0}},
        '{ROW_WORD, OP_SKIP,  8'h00, 8'h00, 9'h100, 4'd0, 1'b1, '{8'h00, 1'b0, 9'd0, 1'b1, 1'b0}},
        // byte extremes in, peek within and beyond the fill
        '{ROW_WORD, OP_PUSH,  8'h00, 8'hFF, 9'h1FF, 4'd0, 1'b1, '{8'h00, 1'b1, 9'd1, 1'b0, 1'b0}},
        '{ROW_WORD, OP_PUSH,  8'hFF, 8'h00, 9'h000, 4'd0, 1'b1, '{8'h00, 1'b1, 9'd2, 1'b0, 1'b0}},
        '{ROW_WORD, OP_PEEK,  8'h00, 8'h01, 9'h000, 4'd0, 1'b1, '{8'hFF, 1'b1, 9'd2, 1'b0, 1'b0}},
        '{ROW_WORD, OP_PEEK,  8'h00, 8'hFF, 9'h000, 4'd0, 1'b1, '{8'h00, 1'b0, 9'd2, 1'b0, 1'b0}},
        '{ROW_WORD, OP_POP,   8'h00, 8'h00, 9'h000, 4'd0, 1'b1, '{8'h00, 1'b1, 9'd1, 1'b0, 1'b0}},
        // spare codes change nothing; clear empties
        '{ROW_WORD, OP_SPARE_LO, 8'hFF, 8'h00, 9'h000, 4'd0, 1'b1,
          '{8'h00, 1'b0, 9'd1, 1'b0, 1'b0}},
        '{ROW_WORD, OP_SPARE_HI, 8'h00, 8'hFF, 9'h1FF, 4'd0, 1'b1,
          '{8'h00, 1'b0, 9'd1, 1'b0, 1'b0}},
        '{ROW_WORD, OP_CLEAR, 8'h00, 8'h00, 9'h000, 4'd0, 1'b1, '{8'h00, 1'b1, 9'd0, 1'b1, 1'b0}},
        // two-slot ring: fill, drop when full, clipped skip
        '{ROW_CAPACITY, OP_PUSH, 8'h00, 8'h00, 9'h000, 4'd1, 1'b0, NO_RESULT},
        '{ROW_WORD, OP_PUSH,  8'hA5, 8'h00, 9'h000, 4'd0, 1'b0, NO_RESULT},
        '{ROW_WORD, OP_PUSH,  8'h5A, 8'h00, 9'h000, 4'd0, 1'b1, '{8'h00, 1'b1, 9'd2, 1'b0, 1'b1}},
        '{ROW_WORD, OP_PUSH,  8'h77, 8'h00, 9'h000, 4'd0, 1'b1, '{8'h00, 1'b0, 9'd2, 1'b0, 1'b1}},
        '{ROW_WORD, OP_POP,   8'h00, 8'h00, 9'h000, 4'd0, 1'b0, NO_RESULT},
        '{ROW_WORD, OP_SKIP,  8'h00, 8'h00, 9'h003, 4'd0, 1'b1, '{8'h00, 1'b0, 9'd0, 1'b1, 1'b0}},
        // exponent 0 behaves as 1
        '{ROW_CAPACITY, OP_PUSH, 8'h00, 8'h00, 9'h000, 4'd0, 1'b0, NO_RESULT},
        '{ROW_WORD, OP_PUSH,  8'h3C, 8'h00, 9'h000, 4'd0, 1'b0, NO_RESULT},
        '{ROW_WORD, OP_PUSH,  8'hC3, 8'h00, 9'h000, 4'd0, 1'b0, NO_RESULT},
        '{ROW_WORD, OP_PEEK,  8'h00, 8'h01, 9'h000, 4'd0, 1'b0, NO_RESULT},
        // exponent 15 behaves as 8, and the write empties the ring
        '{ROW_CAPACITY, OP_PUSH, 8'h00, 8'h00, 9'h000, 4'd15, 1'b0, NO_RESULT},
        '{ROW_WORD, OP_PUSH,  8'hAA, 8'h00, 9'h000, 4'd0, 1'b0, NO_RESULT},
        '{ROW_WORD, OP_SKIP,  8'h00, 8'h00, 9'h1FF, 4'd0, 1'b1, '{8'h00, 1'b0, 9'd0, 1'b1, 1'b0}},
        '{ROW_WORD, OP_POP,   8'h00, 8'h00, 9'h000, 4'd0, 1'b0, NO_RESULT}
    };

    // Capacity settings for the random phases; a negative entry means a
    // fresh random exponent.
    localparam int PHASES = 9;
    localparam int PHASE_SETTING [PHASES] = '{8, 3, 1, 15, 5, 2, 0, -1, -1};
    localparam int PHASE_WORDS = 75;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                done;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;
    logic [OP_W-1:0]     operation;
    logic [BYTE_W-1:0]   data_in;
    logic [BYTE_W-1:0]   peek_offset;
    logic [CNT_W-1:0]    skip_count;
    logic [BYTE_W-1:0]   data_out;
    logic                ok;
    logic [FILL_W-1:0]   fill_level;
    logic                is_empty;
    logic                is_full;

    byte_ring_fifo_with_peek_skip_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .done        (done),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .operation   (operation),
        .data_in     (data_in),
        .peek_offset (peek_offset),
        .skip_count  (skip_count),
        .data_out    (data_out),
        .ok          (ok),
        .fill_level  (fill_level),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

    // Shadow of the ring: our own pointers, slots and exponent register.
    logic [CNT_W-1:0]  shadow_wr;
    logic [CNT_W-1:0]  shadow_rd;
    logic [BYTE_W-1:0] shadow_ring [RING_DEPTH];
    logic [CFG_W-1:0]  shadow_cap_log2;

    // Results owed by the block, oldest first.
    fifo_result_t owed_results [$];

    int mismatches;
    int words_sent;
    int results_seen;
    int cap_writes;
    int refusals;
    int full_hits;
    int cycle_count;
    bit quiet_stretch;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Shadow model
    // ---------------------------------------------------------------

    function automatic void clear_shadow();
        shadow_wr = '0;
        shadow_rd = '0;
        for (int i = 0; i < RING_DEPTH; i++)
            shadow_ring[i] = '0;
    endfunction

    // Exponent in force: below 1 reads as 1, beyond the storage as the top.
    function automatic int unsigned cap_now();
        int unsigned k;
        k = shadow_cap_log2;
        if (k < 1)
            k = 1;
        if (k > MAX_LOG2)
            k = MAX_LOG2;
        return 1 << k;
    endfunction

    // Pointers wrap together at 9 bits, so the plain difference is the fill.
    function automatic int unsigned fill_now();
        logic [CNT_W-1:0] diff;
        diff = shadow_wr - shadow_rd;
        return diff;
    endfunction

    // Applies one command word to the shadow ring and returns the word the
    // block should answer with.
    function automatic fifo_result_t apply_command(input logic [OP_W-1:0]   code,
                                                   input logic [BYTE_W-1:0] din,
                                                   input logic [BYTE_W-1:0] off,
                                                   input logic [CNT_W-1:0]  cnt);
        fifo_result_t      r;
        int unsigned       cap;
        int unsigned       fill;
        int unsigned       n;
        logic [BYTE_W-1:0] slot_mask;
        r         = NO_RESULT;
        cap       = cap_now();
        slot_mask = BYTE_W'(cap - 1);
        fill      = fill_now();
        case (code)
            OP_PUSH:
                if (fill < cap)
                begin
                    shadow_ring[BYTE_W'(shadow_wr) & slot_mask] = din;
                    shadow_wr = shadow_wr + 1'b1;
                    r.ok      = 1'b1;
                end
            OP_POP:
                if (fill != 0)
                begin
                    r.byte_val = shadow_ring[BYTE_W'(shadow_rd) & slot_mask];
                    shadow_rd  = shadow_rd + 1'b1;
                    r.ok       = 1'b1;
                end
            OP_PEEK:
                if (off < fill)
                begin
                    r.byte_val = shadow_ring[BYTE_W'(shadow_rd + CNT_W'(off)) & slot_mask];
                    r.ok       = 1'b1;
                end
            OP_SKIP:
            begin
                // saturates at the fill; ok drops only when clipped
                n         = (cnt < fill) ? cnt : fill;
                shadow_rd = shadow_rd + CNT_W'(n);
                r.ok      = (cnt <= fill);
            end
            OP_CLEAR:
            begin
                clear_shadow();
                r.ok = 1'b1;
            end
            default:
                ;
        endcase
        fill    = fill_now();
        r.level = FILL_W'(fill);
        r.empty = (fill == 0);
        r.full  = (fill == cap);
        if (!r.ok)
            refusals++;
        if (r.full)
            full_hits++;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Presents one word and holds it until taken. start is left high so a
    // back-to-back word needs no second assignment in the same step.
    task automatic send_word(input logic [OP_W-1:0]   code,
                             input logic [BYTE_W-1:0] din,
                             input logic [BYTE_W-1:0] off,
                             input logic [CNT_W-1:0]  cnt,
                             input logic              typed,
                             input fifo_result_t      typed_want);
        fifo_result_t predicted;
        start       <= 1'b1;
        operation   <= code;
        data_in     <= din;
        peek_offset <= off;
        skip_count  <= cnt;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_command(code, din, off, cnt);
        owed_results.push_back(typed ? typed_want : predicted);
        words_sent++;
    endtask

    // Mostly back-to-back or short gaps, now and then a long one; none at
    // all during a quiet stretch.
    task automatic sender_gap();
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        if (quiet_stretch || roll < 55)
            n = 0;
        else if (roll < 85)
            n = $urandom_range(1, 3);
        else if (roll < 97)
            n = $urandom_range(4, 12);
        else
            n = $urandom_range(20, 60);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off until every owed word has come back, then a little margin.
    task automatic wait_drained();
        start <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Exponent writes also empty the ring, so only ever done when idle.
    task automatic write_capacity(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we          <= 1'b0;
        shadow_cap_log2  = value;
        clear_shadow();
        cap_writes++;
    endtask

    // Pushes until two past full, so every phase sees the full flag and a
    // dropped byte.
    task automatic pour_to_full();
        int unsigned total;
        total = cap_now() + 2;
        for (int i = 0; i < total; i++)
        begin
            send_word(OP_PUSH, BYTE_W'($urandom), BYTE_W'($urandom), CNT_W'($urandom),
                      1'b0, NO_RESULT);
            sender_gap();
        end
    endtask

    // Bursts of one traffic shape at a time; the rare codes sprinkle noise.
    task automatic random_traffic(input int words);
        traffic_mode_t     mode;
        int                burst_left;
        int                roll;
        int                fill;
        int                push_lim;
        int                peek_lim;
        int                pop_lim;
        logic [OP_W-1:0]   code;
        logic [BYTE_W-1:0] off;
        logic [CNT_W-1:0]  cnt;
        mode       = MODE_BLEND;
        burst_left = 0;
        for (int k = 0; k < words; k++)
        begin
            if (burst_left == 0)
            begin
                mode          = traffic_mode_t'($urandom_range(0, 2));
                burst_left    = $urandom_range(4, 40);
                quiet_stretch = ($urandom_range(0, 4) == 0);
            end
            burst_left--;
            // sender holds back mid-phase until the block has caught up
            if (k == words / 2)
                wait_drained();
            case (mode)
                MODE_FILL:  begin push_lim = 70; peek_lim = 82; pop_lim = 92; end
                MODE_DRAIN: begin push_lim = 15; peek_lim = 35; pop_lim = 75; end
                default:    begin push_lim = 35; peek_lim = 60; pop_lim = 85; end
            endcase
            fill = fill_now();
            roll = $urandom_range(0, 99);
            if (roll < push_lim)
                code = OP_PUSH;
            else if (roll < peek_lim)
                code = OP_PEEK;
            else if (roll < pop_lim)
                code = OP_POP;
            else if (roll < 97)
                code = OP_SKIP;
            else if (roll < 98)
                code = OP_CLEAR;
            else
                code = OP_SPARE_LO + OP_W'($urandom_range(0, OP_SPARE_HI - OP_SPARE_LO));
            // offsets mostly land inside the fill, sometimes anywhere
            if ($urandom_range(0, 4) != 0)
                off = BYTE_W'($urandom_range(0, (fill > 255) ? 255 : fill));
            else
                off = BYTE_W'($urandom);
            roll = $urandom_range(0, 9);
            if (roll < 6)
                cnt = CNT_W'($urandom_range(0, fill + 1));
            else if (roll < 8)
                cnt = CNT_W'($urandom_range(0, 4));
            else if (roll < 9)
                cnt = CNT_W'(256);
            else
                cnt = CNT_W'($urandom);
            send_word(code, BYTE_W'($urandom), off, cnt, 1'b0, NO_RESULT);
            sender_gap();
        end
        quiet_stretch = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Outputs are sampled on the edge that closes the strobe cycle; the
    // block's own updates at that edge land after this reads them.
    always @(posedge clk)
    begin : result_check
        fifo_result_t want;
        if (rst_n && done)
        begin
            if (owed_results.size() == 0)
                report_mismatch("result word with none owed", 1, 0);
            else
            begin
                want = owed_results.pop_front();
                results_seen++;
                if (data_out !== want.byte_val)
                    report_mismatch("data_out", data_out, want.byte_val);
                if (ok !== want.ok)
                    report_mismatch("ok", ok, want.ok);
                if (fill_level !== want.level)
                    report_mismatch("fill_level", fill_level, want.level);
                if (is_empty !== want.empty)
                    report_mismatch("is_empty", is_empty, want.empty);
                if (is_full !== want.full)
                    report_mismatch("is_full", is_full, want.full);
            end
        end
    end

    // Watchdog: a lost result or a stuck busy ends here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words still owed",
                 cycle_count, owed_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial
    begin
        mismatches      = 0;
        words_sent      = 0;
        results_seen    = 0;
        cap_writes      = 0;
        refusals        = 0;
        full_hits       = 0;
        quiet_stretch   = 1'b0;
        shadow_cap_log2 = brfifo_pkg::CAP_LOG2_RESET;
        clear_shadow();

        rst_n       <= 1'b0;
        start       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        operation   <= OP_PUSH;
        data_in     <= '0;
        peek_offset <= '0;
        skip_count  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows first
        for (int r = 0; r < SCRIPT_ROWS; r++)
        begin
            if (SCRIPT[r].kind == ROW_CAPACITY)
                write_capacity(SCRIPT[r].cap_setting);
            else
            begin
                send_word(SCRIPT[r].code, SCRIPT[r].din, SCRIPT[r].off, SCRIPT[r].cnt,
                          SCRIPT[r].typed, SCRIPT[r].want);
                sender_gap();
            end
        end

        // random phases, one capacity setting each
        for (int p = 0; p < PHASES; p++)
        begin
            if (PHASE_SETTING[p] < 0)
                write_capacity(CFG_W'($urandom_range(0, 15)));
            else
                write_capacity(CFG_W'(PHASE_SETTING[p]));
            pour_to_full();
            random_traffic(PHASE_WORDS);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d command words over %0d capacity settings, %0d result words checked",
                 words_sent, cap_writes + 1, results_seen);
        $display("%0d refused or clipped operations, ring full after %0d operations",
                 refusals, full_hits);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
src/brfifo_pkg.sv
src/brfifo_ctrl.sv
src/brfifo_dp.sv
src/byte_ring_fifo_with_peek_skip_unit.sv
src/brfifo_chk.sv
tb/tb_byte_ring_fifo_with_peek_skip_unit.sv
